// ----- hdl/tgss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tgss_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CFG_SENSOR_CENTER  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIP_WINDOW    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECOVER_WINDOW = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STEP       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_CENTER   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_TRIM     = 3'd5;

  localparam logic [9:0] RST_SENSOR_CENTER  = 10'd500;
  localparam logic [9:0] RST_TRIP_WINDOW    = 10'd120;
  localparam logic [9:0] RST_RECOVER_WINDOW = 10'd85;
  localparam logic [7:0] RST_MAX_STEP       = 8'd5;
  localparam logic [7:0] RST_DRIVE_CENTER   = 8'd128;
  localparam logic [7:0] RST_DRIVE_TRIM     = 8'd0;

  localparam logic [7:0] TRIP_RELOAD    = 8'd250;
  localparam logic [8:0] FULL_AUTHORITY = 9'd500;

  // floor(n / 125) = (n * DIV_K) >> DIV_SHIFT for n < 2^16
  localparam int unsigned DIV_SHIFT = 23;
  localparam logic [32:0] DIV_K = 33'd67109;

  typedef struct packed {
    logic signed [9:0] req;
    logic [7:0]        trip;
    logic [8:0]        auth;
  } stage1_t;

  typedef struct packed {
    logic [19:0] prod;
    logic [7:0]  trip;
    logic [8:0]  auth;
  } stage2_t;

  typedef struct packed {
    logic        neg;
    logic [9:0]  quot;
    logic [7:0]  trip;
    logic [8:0]  auth;
  } stage3_t;

endpackage

`default_nettype wire

// ----- hdl/torque_guarded_steering_slew.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall   | steer_request, torque_a, torque_b, armed
// out_     | output    | out_valid/out_stall | floating, drive_a, drive_b, trip_count,
//          |           |                     | authority_level, applied_steer
// cfg_     | input     | cfg_we              | cfg_index, cfg_wdata
//
// one request per cycle sustained while out_stall is low; registered stages from input to result
// are trip/authority update, scale multiply, divide by 500, slew and drive stage
// synchronous active-low reset clears the state, the steer and drive registers and all valids
// in_stall rises only when every stage holds a request and out_stall is high

module torque_guarded_steering_slew
  import tgss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [9:0]    in_steer_request,
  input  wire logic [9:0]           in_torque_a,
  input  wire logic [9:0]           in_torque_b,
  input  wire logic                 in_armed,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_floating,
  output logic [7:0]                out_drive_a,
  output logic [7:0]                out_drive_b,
  output logic [7:0]                out_trip_count,
  output logic [8:0]                out_authority_level,
  output logic signed [9:0]         out_applied_steer,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata
);

  logic [9:0]        sensor_center_r;
  logic [9:0]        trip_window_r;
  logic [9:0]        recover_window_r;
  logic [7:0]        max_step_r;
  logic [7:0]        drive_center_r;
  logic signed [7:0] drive_trim_r;

  logic [7:0] trip_r, trip_nxt;
  logic [8:0] auth_r, auth_nxt;

  logic    v1_r, v2_r, v3_r, out_valid_r;
  stage1_t s1_r, s1_nxt;
  stage2_t s2_r, s2_nxt;
  stage3_t s3_r, s3_nxt;

  logic                rdy1, rdy2, rdy3, rdy4, accept;
  logic                floating_r;
  logic [7:0]          drive_a_r, drive_a_nxt;
  logic [7:0]          drive_b_r, drive_b_nxt;
  logic [7:0]          trip_out_r;
  logic [8:0]          auth_out_r;
  logic signed [9:0]   steer_r, steer_nxt;

  assign rdy4   = !out_valid_r || !out_stall;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign accept = in_valid && rdy1;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_center_r  <= RST_SENSOR_CENTER;
      trip_window_r    <= RST_TRIP_WINDOW;
      recover_window_r <= RST_RECOVER_WINDOW;
      max_step_r       <= RST_MAX_STEP;
      drive_center_r   <= RST_DRIVE_CENTER;
      drive_trim_r     <= RST_DRIVE_TRIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENSOR_CENTER:  sensor_center_r  <= cfg_wdata;
        CFG_TRIP_WINDOW:    trip_window_r    <= cfg_wdata;
        CFG_RECOVER_WINDOW: recover_window_r <= cfg_wdata;
        CFG_MAX_STEP:       max_step_r       <= cfg_wdata[7:0];
        CFG_DRIVE_CENTER:   drive_center_r   <= cfg_wdata[7:0];
        CFG_DRIVE_TRIM:     drive_trim_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // trip detection and authority ramp
  logic signed [11:0] ctr, hi_top, hi_bot, lo_top, lo_bot, ta, tb;
  logic               tripped, recovering;

  always_comb begin
    ctr    = signed'({2'b00, sensor_center_r});
    hi_top = ctr + signed'({2'b00, trip_window_r});
    hi_bot = ctr - signed'({2'b00, trip_window_r});
    lo_top = ctr + signed'({2'b00, recover_window_r});
    lo_bot = ctr - signed'({2'b00, recover_window_r});
    ta     = signed'({2'b00, in_torque_a});
    tb     = signed'({2'b00, in_torque_b});
    tripped = (ta > hi_top) || (ta < hi_bot) || (tb > hi_top) || (tb < hi_bot) || !in_armed;
    recovering = (ta < lo_top) && (ta > lo_bot) && (tb < lo_top) && (tb > lo_bot);

    if (tripped) begin
      trip_nxt = TRIP_RELOAD;
    end else if (trip_r != 8'd0 && recovering) begin
      trip_nxt = trip_r - 8'd1;
    end else begin
      trip_nxt = trip_r;
    end

    if (trip_nxt != 8'd0 && auth_r != 9'd0) begin
      auth_nxt = auth_r - 9'd1;
    end else if (trip_nxt == 8'd0 && auth_r < FULL_AUTHORITY) begin
      auth_nxt = auth_r + 9'd1;
    end else begin
      auth_nxt = auth_r;
    end

    s1_nxt.req  = in_steer_request;
    s1_nxt.trip = trip_nxt;
    s1_nxt.auth = auth_nxt;
  end

  // request times authority
  always_comb begin
    s2_nxt.prod = {{10{s1_r.req[9]}}, s1_r.req} * {11'd0, s1_r.auth};
    s2_nxt.trip = s1_r.trip;
    s2_nxt.auth = s1_r.auth;
  end

  // magnitude divided by 500 as (m >> 2) / 125 by reciprocal
  logic [19:0] mag;
  logic [32:0] qprod;

  always_comb begin
    mag   = s2_r.prod[19] ? (20'd0 - s2_r.prod) : s2_r.prod;
    qprod = {17'd0, mag[17:2]} * DIV_K;
    s3_nxt.neg  = s2_r.prod[19];
    s3_nxt.quot = qprod[DIV_SHIFT+9:DIV_SHIFT];
    s3_nxt.trip = s2_r.trip;
    s3_nxt.auth = s2_r.auth;
  end

  // slew limit and drive levels
  logic signed [11:0] scaled, cur, diff, mstep, steer_ext, sum_a, sum_b;

  always_comb begin
    scaled = s3_r.neg ? (12'sd0 - signed'({2'b00, s3_r.quot})) : signed'({2'b00, s3_r.quot});
    cur    = 12'(steer_r);
    diff   = cur - scaled;
    mstep  = signed'({4'd0, max_step_r});
    if (diff <= mstep && diff >= -mstep) begin
      steer_nxt = scaled[9:0];
    end else if (scaled > cur) begin
      steer_nxt = 10'(cur + mstep);
    end else begin
      steer_nxt = 10'(cur - mstep);
    end
    steer_ext = 12'(steer_nxt);
    sum_a = signed'({4'd0, drive_center_r}) + steer_ext + 12'(drive_trim_r);
    sum_b = signed'({4'd0, drive_center_r}) - steer_ext + 12'(drive_trim_r);
    if (s3_r.trip != 8'd0) begin
      drive_a_nxt = drive_a_r;
      drive_b_nxt = drive_b_r;
    end else begin
      drive_a_nxt = sum_a < 0 ? 8'd0 : (sum_a > 12'sd255 ? 8'd255 : sum_a[7:0]);
      drive_b_nxt = sum_b < 0 ? 8'd0 : (sum_b > 12'sd255 ? 8'd255 : sum_b[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_r      <= '0;
      auth_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      steer_r     <= '0;
      drive_a_r   <= '0;
      drive_b_r   <= '0;
    end else begin
      if (accept) begin
        trip_r <= trip_nxt;
        auth_r <= auth_nxt;
      end
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        out_valid_r <= v3_r;
      end
      if (rdy4 && v3_r) begin
        steer_r   <= steer_nxt;
        drive_a_r <= drive_a_nxt;
        drive_b_r <= drive_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      s3_r <= s3_nxt;
    end
    if (rdy4 && v3_r) begin
      floating_r <= (s3_r.trip != 8'd0);
      trip_out_r <= s3_r.trip;
      auth_out_r <= s3_r.auth;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_floating        = floating_r;
  assign out_drive_a         = drive_a_r;
  assign out_drive_b         = drive_b_r;
  assign out_trip_count      = trip_out_r;
  assign out_authority_level = auth_out_r;
  assign out_applied_steer   = steer_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r && out_stall))
    else $error("input stalled with a free stage");

  a_trip_range: assert property (@(posedge clk) disable iff (!rst_n)
    trip_r <= TRIP_RELOAD)
    else $error("trip counter out of range");

  a_auth_range: assert property (@(posedge clk) disable iff (!rst_n)
    auth_r <= FULL_AUTHORITY)
    else $error("authority out of range");

  a_float_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (floating_r == (trip_out_r != 8'd0)))
    else $error("floating flag disagrees with trip count");

endmodule

`default_nettype wire
